// File: rtl/core/sdes_pkg.sv
package sdes_pkg;

    // Permutation tables hold the source bit (LSB-numbered) for each output
    // bit, listed from the output MSB down.
    localparam logic [3:0] P10_SRC [10] = '{4'd7, 4'd5, 4'd8, 4'd3, 4'd6,
                                            4'd0, 4'd9, 4'd1, 4'd2, 4'd4};
    localparam logic [3:0] P8_SRC  [8]  = '{4'd4, 4'd7, 4'd3, 4'd6,
                                            4'd2, 4'd5, 4'd0, 4'd1};
    localparam logic [1:0] EP_SRC  [8]  = '{2'd0, 2'd3, 2'd2, 2'd1,
                                            2'd2, 2'd1, 2'd0, 2'd3};
    localparam logic [1:0] P4_SRC  [4]  = '{2'd2, 2'd0, 2'd1, 2'd3};
    localparam logic [2:0] IP_SRC  [8]  = '{3'd6, 3'd2, 3'd5, 3'd7,
                                            3'd4, 3'd0, 3'd3, 3'd1};
    localparam logic [2:0] IPI_SRC [8]  = '{3'd4, 3'd7, 3'd5, 3'd3,
                                            3'd1, 3'd6, 3'd0, 3'd2};

    // S-boxes packed by column; row r sits in bits [7-2r -: 2].
    localparam logic [7:0] S0_TAB [4] = '{8'h73, 8'h29, 8'hD7, 8'h8E};
    localparam logic [7:0] S1_TAB [4] = '{8'h2E, 8'h41, 8'h94, 8'hF3};

    typedef struct packed {
        logic [7:0] k1;
        logic [7:0] k2;
    } sdes_subkeys_t;

    function automatic logic [9:0] perm_p10(input logic [9:0] val);
        logic [9:0] res;
        res = '0;
        for (int i = 0; i < 10; i++)
        begin
            res[9 - i] = val[P10_SRC[i]];
        end
        return res;
    endfunction

    function automatic logic [7:0] perm_p8(input logic [9:0] val);
        logic [7:0] res;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            res[7 - i] = val[P8_SRC[i]];
        end
        return res;
    endfunction

    function automatic logic [7:0] perm_ep(input logic [3:0] val);
        logic [7:0] res;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            res[7 - i] = val[EP_SRC[i]];
        end
        return res;
    endfunction

    function automatic logic [3:0] perm_p4(input logic [3:0] val);
        logic [3:0] res;
        res = '0;
        for (int i = 0; i < 4; i++)
        begin
            res[3 - i] = val[P4_SRC[i]];
        end
        return res;
    endfunction

    function automatic logic [7:0] perm_ip(input logic [7:0] val);
        logic [7:0] res;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            res[7 - i] = val[IP_SRC[i]];
        end
        return res;
    endfunction

    function automatic logic [7:0] perm_ipi(input logic [7:0] val);
        logic [7:0] res;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            res[7 - i] = val[IPI_SRC[i]];
        end
        return res;
    endfunction

    // Row from the outer bits, column from the inner bits.
    function automatic logic [1:0] sbox_lookup(input logic [7:0] col_word,
                                               input logic [1:0] row);
        logic [1:0] res;
        case (row)
            2'd0:    res = col_word[7:6];
            2'd1:    res = col_word[5:4];
            2'd2:    res = col_word[3:2];
            2'd3:    res = col_word[1:0];
            default: res = col_word[1:0];
        endcase
        return res;
    endfunction

    // Rotate each 5-bit half left by one / by two.
    function automatic logic [9:0] rot_halves_1(input logic [9:0] val);
        return {val[8:5], val[9], val[3:0], val[4]};
    endfunction

    function automatic logic [9:0] rot_halves_2(input logic [9:0] val);
        return {val[7:5], val[9:8], val[2:0], val[4:3]};
    endfunction

endpackage

// File: rtl/core/sdes_key_sched.sv
module sdes_key_sched (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cipher_key_wr_en,
    input  logic [9:0]             cipher_key,
    output sdes_pkg::sdes_subkeys_t subkeys
);

    // Subkeys are worked out once, on the key write. All-zero key gives
    // all-zero subkeys, so reset simply clears them.
    logic [9:0]              p10_key;
    logic [9:0]              rot1_key;
    logic [9:0]              rot3_key;
    sdes_pkg::sdes_subkeys_t subkeys_reg;
    sdes_pkg::sdes_subkeys_t subkeys_next;

    always_comb
    begin
        p10_key         = sdes_pkg::perm_p10(cipher_key);
        rot1_key        = sdes_pkg::rot_halves_1(p10_key);
        rot3_key        = sdes_pkg::rot_halves_2(rot1_key);
        subkeys_next.k1 = sdes_pkg::perm_p8(rot1_key);
        subkeys_next.k2 = sdes_pkg::perm_p8(rot3_key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subkeys_reg <= '0;
        end
        else if (cipher_key_wr_en)
        begin
            subkeys_reg <= subkeys_next;
        end
    end

    assign subkeys = subkeys_reg;

endmodule

// File: rtl/core/sdes_round.sv
module sdes_round (
    input  logic [3:0] left_in,
    input  logic [3:0] right_in,
    input  logic [7:0] subkey,
    output logic [3:0] left_out
);

    // fk: L xor F(R, K); R passes through in the caller.
    logic [7:0] mixed;
    logic [1:0] s0_out;
    logic [1:0] s1_out;

    always_comb
    begin
        mixed    = sdes_pkg::perm_ep(right_in) ^ subkey;
        s0_out   = sdes_pkg::sbox_lookup(sdes_pkg::S0_TAB[mixed[6:5]],
                                         {mixed[7], mixed[4]});
        s1_out   = sdes_pkg::sbox_lookup(sdes_pkg::S1_TAB[mixed[2:1]],
                                         {mixed[3], mixed[0]});
        left_out = left_in ^ sdes_pkg::perm_p4({s0_out, s1_out});
    end

endmodule

// File: rtl/core/sdes_block_encrypt.sv
// S-DES block encryption, one 8-bit block per beat.
//
// Key: write the 10-bit key on cipher_key with cipher_key_wr_en high for one
// clock, only while the block is idle. Subkeys are derived on that write.
// Input: plain_byte is taken on a clock edge with plain_valid high and
// plain_stall low. Output: cipher_byte is handed over on an edge with
// cipher_valid high and cipher_stall low.
// Path: an input beat is held in the input register, then moves to the result
// register, which drives cipher_valid; the whole cipher is logic between them.
// Throughput: one beat per cycle, sustained while the receiver keeps up; the
// input register and result register form a two-entry pipeline.
// Stall: when cipher_stall holds, the result stays put; one more beat is
// absorbed by the input register, after which plain_stall is raised.
// Reset: asynchronous, active low; both stages empty, subkeys zero as for an all-zero key.
module sdes_block_encrypt (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cipher_key_wr_en,
    input  logic [9:0] cipher_key,
    input  logic       plain_valid,
    output logic       plain_stall,
    input  logic [7:0] plain_byte,
    output logic       cipher_valid,
    input  logic       cipher_stall,
    output logic [7:0] cipher_byte
);

    sdes_pkg::sdes_subkeys_t subkeys;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_valid_next;

    logic       in_move;   // input stage hands its block to the result stage
    logic       in_take;   // new beat accepted on the input side
    logic [7:0] ip_block;
    logic [3:0] round1_left;
    logic [3:0] round2_left;
    logic [7:0] out_byte_next;

    sdes_key_sched u_key_sched (
        .clk              (clk),
        .rst_n            (rst_n),
        .cipher_key_wr_en (cipher_key_wr_en),
        .cipher_key       (cipher_key),
        .subkeys          (subkeys)
    );

    // Round 1 on (L, R) with K1; halves swap; round 2 with K2.
    assign ip_block = sdes_pkg::perm_ip(in_byte_reg);

    sdes_round u_round1 (
        .left_in  (ip_block[7:4]),
        .right_in (ip_block[3:0]),
        .subkey   (subkeys.k1),
        .left_out (round1_left)
    );

    sdes_round u_round2 (
        .left_in  (ip_block[3:0]),
        .right_in (round1_left),
        .subkey   (subkeys.k2),
        .left_out (round2_left)
    );

    assign out_byte_next = sdes_pkg::perm_ipi({round2_left, round1_left});

    // Handshake control.
    assign in_move     = in_valid_reg && (!out_valid_reg || !cipher_stall);
    assign plain_stall = in_valid_reg && !in_move;
    assign in_take     = plain_valid && !plain_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && cipher_stall;
        if (in_move)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_take || (in_valid_reg && !in_move);
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= plain_byte;
        end
        if (in_move)
        begin
            out_byte_reg <= out_byte_next;
        end
    end

    assign cipher_valid = out_valid_reg;
    assign cipher_byte  = out_byte_reg;

`ifndef SYNTHESIS
    // Input side only pushes back when both stages are full and blocked.
    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        plain_stall |-> (in_valid_reg && out_valid_reg && cipher_stall))
        else $error("plain_stall raised with room in the pipeline");

    // A block leaving the input stage always shows up as a result.
    a_move_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        in_move |=> cipher_valid)
        else $error("block lost between input and result stage");

    // A fresh result only follows a full input stage.
    a_result_has_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cipher_valid) |-> $past(in_valid_reg))
        else $error("result appeared without a block in the input stage");
`endif

endmodule
